FILE: design/erm_pkg.sv
// Shared constants, types and arithmetic constants for the echo range median filter.
package erm_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int MEDIAN_IDX  = WINDOW_SIZE / 2;
    localparam int CNT_W       = $clog2(WINDOW_SIZE);
    localparam int IDX_W       = $clog2(WINDOW_SIZE - 1);

    localparam int STAMP_W = 16;
    localparam int DIST_W  = 15;
    localparam int TEMP_W  = 8;
    localparam int SPEED_W = 12;
    localparam int PROD_W  = STAMP_W + SPEED_W;

    localparam logic [12:0] SPEED_BASE = 13'd3310;
    localparam logic [12:0] SPEED_MUL  = 13'd6;

    // floor(x / 12500) == (x * RECIP_M) >> RECIP_SHIFT for every x below 2**28
    localparam int          RECIP_W     = 29;
    localparam int          RECIP_SHIFT = 42;
    localparam logic [28:0] RECIP_M     = 29'd351843721;
    localparam int          QPROD_W     = PROD_W + RECIP_W;

    localparam logic [TEMP_W-1:0] TEMP_RESET    = 8'd26;
    localparam logic [DIST_W-1:0] NO_ECHO_RESET = 15'd16000;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AIR_TEMPERATURE  = 8'd0,
        CFG_NO_ECHO_DISTANCE = 8'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        REQ_RISING  = 2'd0,
        REQ_FALLING = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_type_t;

    typedef logic [DIST_W-1:0] dist_t;

endpackage

FILE: design/erm_median.sv
// Rank-based median selector over one full reading window.
module erm_median (
    input  erm_pkg::dist_t window_in [erm_pkg::WINDOW_SIZE],
    output erm_pkg::dist_t median_out
);

    logic [erm_pkg::CNT_W-1:0] rank [erm_pkg::WINDOW_SIZE];

    always_comb begin
        for (int i = 0; i < erm_pkg::WINDOW_SIZE; i++) begin
            rank[i] = '0;
            for (int j = 0; j < erm_pkg::WINDOW_SIZE; j++) begin
                if (j != i) begin
                    if ((window_in[j] < window_in[i]) ||
                        ((window_in[j] == window_in[i]) && (j < i))) begin
                        rank[i] = rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        median_out = '0;
        for (int i = 0; i < erm_pkg::WINDOW_SIZE; i++) begin
            if (rank[i] == erm_pkg::CNT_W'(erm_pkg::MEDIAN_IDX)) begin
                median_out = median_out | window_in[i];
            end
        end
    end

endmodule

FILE: design/echo_range_median_filter.sv
// Echo range median filter top level: pulse timing, distance conversion and median window.
// Rising and falling edge events time an echo pulse; each falling edge after a rising edge,
// and each window-ended event, yields one reading in 1/16 cm, and every fifth reading
// produces the median of the last five on the result channel. The block takes one item per
// cycle unless stalled; an accepted item passes through the registered pulse multiply and
// reciprocal multiply for the divide by 12500, then median selection into the result register,
// and a stall on the result side backs up through those stages before the input stops.
// Configuration writes are accepted at any time and must only be issued while idle.
module echo_range_median_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] capture_stamp
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [14:0] median_distance, [15] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [erm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [erm_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [erm_pkg::TEMP_W-1:0]  temp_reg;
    erm_pkg::dist_t              no_echo_reg;
    logic                        awaiting_reg;
    logic [erm_pkg::STAMP_W-1:0] start_reg;

    logic                        s1_valid_reg;
    logic                        s1_timeout_reg;
    logic [erm_pkg::PROD_W-1:0]  s1_prod_reg;
    erm_pkg::dist_t              s1_noecho_reg;

    logic                        s2_valid_reg;
    erm_pkg::dist_t              s2_reading_reg;

    erm_pkg::dist_t              win_reg [erm_pkg::WINDOW_SIZE-1];
    logic [erm_pkg::CNT_W-1:0]   count_reg;

    logic                        m_valid_reg;
    erm_pkg::dist_t              m_data_reg;

    logic                        in_go;
    logic                        s1_go;
    logic                        s2_go;
    logic                        out_free;
    logic                        is_rising;
    logic                        takes_reading;
    logic                        window_full;

    logic [erm_pkg::STAMP_W-1:0] stop;
    logic [erm_pkg::STAMP_W-1:0] width;
    logic signed [12:0]          speed_wide;
    logic [erm_pkg::SPEED_W-1:0] speed;
    logic [erm_pkg::PROD_W-1:0]  prod;
    logic [erm_pkg::QPROD_W-1:0] qprod;
    erm_pkg::dist_t              quotient;

    erm_pkg::dist_t              full_window [erm_pkg::WINDOW_SIZE];
    erm_pkg::dist_t              median;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign s2_go     = s2_valid_reg && out_free;
    assign s1_go     = s1_valid_reg && (!s2_valid_reg || s2_go);
    assign s_tready  = !s1_valid_reg || s1_go;
    assign in_go     = s_tvalid && s_tready;

    assign is_rising     = (s_tuser == erm_pkg::REQ_RISING);
    assign takes_reading = (s_tuser == erm_pkg::REQ_TIMEOUT) ||
                           ((s_tuser == erm_pkg::REQ_FALLING) && awaiting_reg);

    assign stop  = s_tdata;
    assign width = (stop > start_reg) ? (stop - start_reg) : (16'hffff - start_reg + stop);

    assign speed_wide = $signed(erm_pkg::SPEED_BASE) +
                        $signed({{5{temp_reg[7]}}, temp_reg}) * $signed(erm_pkg::SPEED_MUL);
    assign speed      = speed_wide[erm_pkg::SPEED_W-1:0];
    assign prod       = erm_pkg::PROD_W'(width) * erm_pkg::PROD_W'(speed);

    assign qprod    = erm_pkg::QPROD_W'(s1_prod_reg) * erm_pkg::QPROD_W'(erm_pkg::RECIP_M);
    assign quotient = qprod[erm_pkg::RECIP_SHIFT +: erm_pkg::DIST_W];

    assign window_full = (count_reg == erm_pkg::CNT_W'(erm_pkg::WINDOW_SIZE - 1));

    always_comb begin
        for (int i = 0; i < erm_pkg::WINDOW_SIZE - 1; i++) begin
            full_window[i] = win_reg[i];
        end
        full_window[erm_pkg::WINDOW_SIZE-1] = s2_reading_reg;
    end

    erm_median u_median (
        .window_in  (full_window),
        .median_out (median)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_reg    <= erm_pkg::TEMP_RESET;
            no_echo_reg <= erm_pkg::NO_ECHO_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                erm_pkg::CFG_AIR_TEMPERATURE:  temp_reg    <= cfg_data[erm_pkg::TEMP_W-1:0];
                erm_pkg::CFG_NO_ECHO_DISTANCE: no_echo_reg <= cfg_data[erm_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b0;
            start_reg    <= '0;
        end else if (in_go) begin
            if (is_rising) begin
                awaiting_reg <= 1'b1;
                start_reg    <= s_tdata;
            end else if (takes_reading) begin
                awaiting_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_go) begin
            s1_valid_reg <= takes_reading;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_go) begin
            s1_timeout_reg <= (s_tuser == erm_pkg::REQ_TIMEOUT);
            s1_prod_reg    <= prod;
            s1_noecho_reg  <= no_echo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_go) begin
            s2_valid_reg <= 1'b1;
        end else if (s2_go) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s2_reading_reg <= s1_timeout_reg ? s1_noecho_reg : quotient;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (s2_go) begin
            count_reg <= window_full ? '0 : count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go && !window_full) begin
            win_reg[count_reg[erm_pkg::IDX_W-1:0]] <= s2_reading_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_go && window_full) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go && window_full) begin
            m_data_reg <= median;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule

FILE: design/erm_checker.sv
// Port-level checker for the echo range median filter, bound to the top level.
module erm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        cfg_ready
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[15])
        else $error("result padding bit set");

    a_ready_after_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> s_tready && cfg_ready)
        else $error("input not ready after reset");

endmodule

bind echo_range_median_filter erm_checker u_erm_checker (.*);
